[src/krss_pkg.sv]
// Shared types and constants for the keyed record sort and search core.
package krss_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int KEY_BYTES_DEFAULT = 8;
    localparam int KEY_W             = 64;
    localparam int HANDLE_W          = 8;
    localparam int POS_W             = 6;
    localparam int COUNT_W           = 7;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_SORT   = 3'd2,
        OP_SEARCH = 3'd3,
        OP_LIST   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        FIELD_NUMBER    = 2'd0,
        FIELD_NAME      = 2'd1,
        FIELD_SPECIALTY = 2'd2,
        FIELD_NONE      = 2'd3
    } field_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    specialty;
        logic [KEY_W-1:0]    name;
        logic [KEY_W-1:0]    number;
    } record_t;

    typedef struct packed {
        op_t     op;
        field_t  field;
        record_t rec;
    } cmd_t;

    typedef struct packed {
        logic               status;
        logic               last;
        logic [COUNT_W-1:0] match_count;
        logic [POS_W-1:0]   position;
        logic [HANDLE_W-1:0] handle;
        logic               found;
    } result_t;

endpackage

[src/krss_front.sv]
// Request front end: takes stream requests, masks keys and drops unknown codes.
module krss_front #(
    parameter int KEY_BYTES = krss_pkg::KEY_BYTES_DEFAULT
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [199:0]         s_tdata,
    input  logic [4:0]           s_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output krss_pkg::cmd_t       q_cmd
);
    import krss_pkg::*;

    localparam logic [KEY_W-1:0] KeyMask = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

    logic known;

    assign s_tready = !q_full;
    // Codes above the list request are taken from the bus and then discarded.
    assign known    = (s_tuser[2:0] == OP_CLEAR) || (s_tuser[2:0] == OP_APPEND)
                   || (s_tuser[2:0] == OP_SORT) || (s_tuser[2:0] == OP_SEARCH)
                   || (s_tuser[2:0] == OP_LIST);
    assign q_push   = s_tvalid && !q_full && known;

    always_comb
    begin
        q_cmd               = '0;
        q_cmd.op            = op_t'(s_tuser[2:0]);
        q_cmd.field         = field_t'(s_tuser[4:3]);
        q_cmd.rec.number    = s_tdata[63:0] & KeyMask;
        q_cmd.rec.name      = s_tdata[127:64] & KeyMask;
        q_cmd.rec.specialty = s_tdata[191:128] & KeyMask;
        q_cmd.rec.handle    = s_tdata[199:192];
    end

endmodule

[src/krss_queue.sv]
// Two-entry request queue between the front end and the table engine.
module krss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  krss_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output krss_pkg::cmd_t pop_cmd
);
    import krss_pkg::*;

    cmd_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign pop_cmd = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop && valid)
            begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop && valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

[src/krss_engine.sv]
// Table engine: record memory, insertion sort, binary search, list scan and result register.
module krss_engine #(
    parameter int DEPTH = krss_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  krss_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output krss_pkg::result_t   m_res
);
    import krss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam result_t ResDone =
        result_t'({1'b0, 1'b1, {(COUNT_W + POS_W + HANDLE_W + 1){1'b0}}});
    localparam result_t ResFull =
        result_t'({1'b1, 1'b1, {(COUNT_W + POS_W + HANDLE_W + 1){1'b0}}});

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_READ, S_SORT_I, S_SORT_X, S_SORT_CMP, S_SORT_PUT,
        S_AFTER_SORT, S_BS, S_BS_CMP, S_LS, S_LS_CMP, S_DONE
    } state_t;

    function automatic result_t make_result(logic f, logic [HANDLE_W-1:0] h,
                                            logic [POS_W-1:0] p, logic [COUNT_W-1:0] c,
                                            logic l, logic st);
        return {st, l, c, p, h, f};
    endfunction

    record_t mem [DEPTH];
    record_t rdata_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          wr_en_reg;
    logic [AW-1:0] wr_addr_reg;
    record_t       wr_data_reg;

    state_t  state_reg;
    state_t  ret_reg;
    cmd_t    cmd_reg;
    field_t  sfield_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    record_t       x_reg;
    logic [CW-1:0] low_reg;
    logic [CW-1:0] hi1_reg;
    logic [AW-1:0] mid_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_pos_reg;
    logic [HANDLE_W-1:0] hit_handle_reg;
    logic [CW-1:0] lcount_reg;
    logic          pend_v_reg;
    result_t       pend_reg;
    result_t       fin_reg;
    result_t       out_reg;
    logic          out_valid_reg;

    logic          out_free;
    logic          out_load;
    logic          out_valid_next;
    result_t       out_next;
    logic          wr_en_next;
    logic [AW-1:0] wr_addr_next;
    record_t       wr_data_next;
    logic          moves;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_next;
    logic          ls_match;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;
    assign mid_sum  = {1'b0, low_reg} + {1'b0, hi1_reg} - (CW + 1)'(1);
    assign mid_next = mid_sum[AW:1];
    assign ls_match = (rdata_reg.specialty == cmd_reg.rec.specialty);

    // A held list match goes out when the next match arrives; the final request waits in S_DONE.
    assign out_load = out_free && ((state_reg == S_DONE)
                   || ((state_reg == S_LS_CMP) && ls_match && pend_v_reg));
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);
    assign out_next = !out_load ? out_reg : ((state_reg == S_DONE) ? fin_reg : pend_reg);

    // A stored record moves up past the held one only on a strict compare, keeping the sort stable.
    always_comb
    begin
        unique case (sfield_reg)
            FIELD_NUMBER:    moves = rdata_reg.number > x_reg.number;
            FIELD_NAME:      moves = rdata_reg.name > x_reg.name;
            default:         moves = rdata_reg.specialty < x_reg.specialty;
        endcase
    end

    always_comb
    begin
        wr_en_next   = 1'b0;
        wr_addr_next = j_reg;
        wr_data_next = x_reg;
        priority if ((state_reg == S_DISPATCH) && (cmd_reg.op == OP_APPEND)
                     && (count_reg != CW'(DEPTH)))
        begin
            wr_en_next   = 1'b1;
            wr_addr_next = count_reg[AW-1:0];
            wr_data_next = cmd_reg.rec;
        end
        else if ((state_reg == S_SORT_CMP) && moves)
        begin
            wr_en_next   = 1'b1;
            wr_data_next = rdata_reg;
        end
        else if (state_reg == S_SORT_PUT)
        begin
            wr_en_next   = 1'b1;
        end
        else
        begin
            wr_en_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_data_reg;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            count_reg     <= '0;
            wr_en_reg     <= 1'b0;
            wr_addr_reg   <= '0;
            wr_data_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            pend_v_reg    <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            wr_en_reg     <= wr_en_next;
            wr_addr_reg   <= wr_addr_next;
            wr_data_reg   <= wr_data_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    i_reg        <= CW'(1);
                    unique case (cmd_reg.op)
                        OP_CLEAR:
                        begin
                            fin_reg   <= ResDone;
                            count_reg <= '0;
                            state_reg <= S_DONE;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                fin_reg <= ResFull;
                            end
                            else
                            begin
                                fin_reg   <= ResDone;
                                count_reg <= count_reg + CW'(1);
                            end
                            state_reg <= S_DONE;
                        end
                        OP_SORT:
                        begin
                            fin_reg    <= ResDone;
                            sfield_reg <= cmd_reg.field;
                            state_reg  <= (cmd_reg.field == FIELD_NONE) ? S_DONE : S_SORT_I;
                        end
                        OP_SEARCH:
                        begin
                            fin_reg    <= ResDone;
                            sfield_reg <= FIELD_NUMBER;
                            state_reg  <= S_SORT_I;
                        end
                        OP_LIST:
                        begin
                            fin_reg    <= ResDone;
                            sfield_reg <= FIELD_SPECIALTY;
                            state_reg  <= S_SORT_I;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_READ:
                begin
                    state_reg <= ret_reg;
                end
                S_SORT_I:
                begin
                    if (i_reg < count_reg)
                    begin
                        rd_addr_reg <= i_reg[AW-1:0];
                        ret_reg     <= S_SORT_X;
                        state_reg   <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_AFTER_SORT;
                    end
                end
                S_SORT_X:
                begin
                    x_reg       <= rdata_reg;
                    j_reg       <= i_reg[AW-1:0];
                    rd_addr_reg <= i_reg[AW-1:0] - AW'(1);
                    ret_reg     <= S_SORT_CMP;
                    state_reg   <= S_READ;
                end
                S_SORT_CMP:
                begin
                    if (moves)
                    begin
                        j_reg       <= j_reg - AW'(1);
                        if (j_reg == AW'(1))
                        begin
                            state_reg <= S_SORT_PUT;
                        end
                        else
                        begin
                            rd_addr_reg <= j_reg - AW'(2);
                            ret_reg     <= S_SORT_CMP;
                            state_reg   <= S_READ;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SORT_PUT;
                    end
                end
                S_SORT_PUT:
                begin
                    i_reg       <= i_reg + CW'(1);
                    state_reg   <= S_SORT_I;
                end
                S_AFTER_SORT:
                begin
                    low_reg    <= '0;
                    hi1_reg    <= count_reg;
                    hit_reg    <= 1'b0;
                    i_reg      <= '0;
                    lcount_reg <= '0;
                    pend_v_reg <= 1'b0;
                    priority if (cmd_reg.op == OP_SEARCH)
                    begin
                        state_reg <= S_BS;
                    end
                    else if (cmd_reg.op == OP_LIST)
                    begin
                        state_reg <= S_LS;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_BS:
                begin
                    if (low_reg < hi1_reg)
                    begin
                        mid_reg     <= mid_next;
                        rd_addr_reg <= mid_next;
                        ret_reg     <= S_BS_CMP;
                        state_reg   <= S_READ;
                    end
                    else
                    begin
                        fin_reg   <= make_result(hit_reg, hit_reg ? hit_handle_reg : '0,
                                                 hit_reg ? POS_W'(hit_pos_reg) : '0,
                                                 '0, 1'b1, 1'b0);
                        state_reg <= S_DONE;
                    end
                end
                S_BS_CMP:
                begin
                    if (cmd_reg.rec.number == rdata_reg.number)
                    begin
                        hit_reg        <= 1'b1;
                        hit_pos_reg    <= mid_reg;
                        hit_handle_reg <= rdata_reg.handle;
                    end
                    if (cmd_reg.rec.number < rdata_reg.number)
                    begin
                        hi1_reg <= CW'(mid_reg);
                    end
                    else
                    begin
                        low_reg <= CW'(mid_reg) + CW'(1);
                    end
                    state_reg <= S_BS;
                end
                S_LS:
                begin
                    if (i_reg < count_reg)
                    begin
                        rd_addr_reg <= i_reg[AW-1:0];
                        ret_reg     <= S_LS_CMP;
                        state_reg   <= S_READ;
                    end
                    else
                    begin
                        if (pend_v_reg)
                        begin
                            fin_reg <= make_result(pend_reg.found, pend_reg.handle,
                                                   pend_reg.position, pend_reg.match_count,
                                                   1'b1, pend_reg.status);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_LS_CMP:
                begin
                    // A match is held back until the next one shows whether it is the final one.
                    if (!ls_match || !pend_v_reg || out_free)
                    begin
                        if (ls_match)
                        begin
                            pend_v_reg <= 1'b1;
                            pend_reg   <= make_result(1'b1, rdata_reg.handle, POS_W'(i_reg),
                                                      COUNT_W'(lcount_reg + CW'(1)),
                                                      1'b0, 1'b0);
                            lcount_reg <= lcount_reg + CW'(1);
                        end
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_LS;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/keyed_record_sort_and_search_core.sv]
// Top level of the keyed record sort and search core.
//
//  Channel | Direction | Handshake          | Payload
//  s_*     | in        | s_tvalid/s_tready  | tdata number, name, specialty, handle; tuser kind
//  m_*     | out       | m_tvalid/m_tready  | tdata result fields; tlast last
//
// Sort is an insertion sort through one registered memory read port. Search first
// sorts by number and then runs a binary search; list first sorts by specialty and
// then scans every record.
// Reset clears the record count but not the memory, which holds no reset value.
// The two-entry request queue lets requests arrive while the engine works, and the
// result register lets the engine continue while a result waits to be taken.
module keyed_record_sort_and_search_core #(
    parameter int DEPTH     = krss_pkg::DEPTH_DEFAULT,
    parameter int KEY_BYTES = krss_pkg::KEY_BYTES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [199:0] s_tdata,   // number_key, name_key, specialty_key, record_handle
    input  logic [4:0]   s_tuser,   // req_type, sort_field
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // found, handle_out, position, match_count, status, pad
    output logic         m_tlast
);
    import krss_pkg::*;

    logic    q_full;
    logic    q_push;
    cmd_t    push_cmd;
    logic    q_pop;
    logic    q_valid;
    cmd_t    pop_cmd;
    result_t res;

    krss_front #(.KEY_BYTES(KEY_BYTES)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    krss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    krss_engine #(.DEPTH(DEPTH)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = {1'b0, res.status, res.match_count, res.position, res.handle, res.found};
    assign m_tlast = res.last;

endmodule

[src/krss_checker.sv]
// Port-level checks on the result stream of the sort and search core.
module krss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[22] |-> m_tlast && !m_tdata[0])
        else $error("dropped append result is not a single final result");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[21:1] == 21'd0)
        else $error("result without a match carries record fields");

    a_more_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[0] && m_tdata[21:15] != 7'd0)
        else $error("intermediate result is not a counted match");

endmodule

bind keyed_record_sort_and_search_core krss_checker u_krss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
